// File: design/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter.
`default_nettype none
package skf_pkg;

	// Fixed field and state widths
	localparam int REG_W      = 20;
	localparam int COV_W      = 21;
	localparam int EST_W      = 32;
	localparam int GAIN_OUT_W = 17;
	localparam int OUT_TDATA_W = 56;

	// Configuration register indexes
	localparam logic REG_PROCESS_NOISE     = 1'b0;
	localparam logic REG_MEASUREMENT_NOISE = 1'b1;

	localparam logic [REG_W-1:0] PROCESS_NOISE_RST     = 20'd66;
	localparam logic [REG_W-1:0] MEASUREMENT_NOISE_RST = 20'd34996;
	localparam logic [COV_W-1:0] COV_MAX               = {COV_W{1'b1}};

	// Sequencer states
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_PREP = 7'b0000010,
		ST_DIV  = 7'b0000100,
		ST_GAIN = 7'b0001000,
		ST_MUL1 = 7'b0010000,
		ST_MUL2 = 7'b0100000,
		ST_FIN  = 7'b1000000
	} skf_state_t;

endpackage
`default_nettype wire

// File: design/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: sequencer, divider and shared multiplier.
`default_nettype none
// One-dimensional Kalman filter with a constant-state model. Each input beat carries one
// signed sensor sample; each output beat carries the new estimate (signed, FRAC_BITS
// fractional bits) and the gain used for that step. The estimate and error covariance
// clear at reset, and the process and measurement noise registers reset to about 0.001
// and 0.534. Each sample passes through the states PREP, DIV, GAIN, MUL1, MUL2 and FIN;
// the input is not ready again until FIN hands the result to the output register, so
// one sample is worked on at a time. The gain is formed by a restoring divider, one
// quotient bit per cycle, followed by two passes through one shared multiplier. The
// result sits in an output register, so the next sample is taken while an earlier
// result still waits for the downstream side. Write the noise registers only while the
// filter is idle.
module scalar_kalman_filter
	import skf_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Input stream
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: sample (SAMPLE_WIDTH bits, signed), zero padding to whole bytes
	input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
	// Output stream
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	// tdata: estimate [31:0] (signed), kalman_gain [48:32], zero padding [55:49]
	output logic [OUT_TDATA_W-1:0]               m_axis_tdata,
	// Configuration write port
	input  wire                                  cfg_we,
	input  wire                                  cfg_addr,
	input  wire  [REG_W-1:0]                     cfg_data
);

	localparam int QW  = FRAC_BITS + 1;          // gain / quotient width
	localparam int DW  = COV_W + 1;              // denominator width
	localparam int NW  = COV_W + FRAC_BITS + 1;  // dividend width
	localparam int CW  = $clog2(QW + 1);
	localparam int MAW = EST_W;                  // multiplier operand A width
	localparam int PW  = MAW + QW;               // product width
	localparam int RW  = PW + 1 - FRAC_BITS;     // rounded product width
	localparam int SW  = 36;                     // estimate sum width
	localparam int TW  = (SAMPLE_WIDTH + FRAC_BITS > EST_W + 1) ?
		SAMPLE_WIDTH + FRAC_BITS : EST_W + 1;

	localparam logic [QW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [PW:0]   HALF = (PW+1)'(1) << (FRAC_BITS - 1);

	localparam logic signed [TW-1:0] TGT_HI = TW'(64'sd2147483647);
	localparam logic signed [TW-1:0] TGT_LO = TW'(-64'sd2147483648);
	localparam logic signed [SW-1:0] EST_HI = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] EST_LO = SW'(-64'sd2147483648);

	skf_state_t                state_q;
	logic [REG_W-1:0]          q_noise_q, r_noise_q;
	logic signed [EST_W-1:0]   prior_q;
	logic [COV_W-1:0]          cov_q;

	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic [COV_W-1:0]          pmid_q;
	logic [DW-1:0]             den_q, rem_q;
	logic                      den_zero_q;
	logic [QW-1:0]             num_q, quo_q, gain_q;
	logic [CW-1:0]             cnt_q;
	logic [MAW-1:0]            mag_q;
	logic                      neg_q;
	logic [PW-1:0]             prod_q;
	logic signed [EST_W-1:0]   est_q;

	logic                      out_valid_q;
	logic [EST_W-1:0]          out_est_q;
	logic [GAIN_OUT_W-1:0]     out_gain_q;

	logic                      in_beat, out_free;

	// Predicted covariance, saturated to the covariance width.
	logic [COV_W:0]            pmid_sum;
	logic [COV_W-1:0]          pmid_c;

	// Denominator and rounded dividend.
	logic [DW-1:0]             den_c;
	logic [NW-1:0]             num_c;

	// Clamped target and distance from the prior estimate.
	logic signed [TW-1:0]      tgt_ext;
	logic signed [EST_W-1:0]   tgt_c;
	logic signed [EST_W:0]     diff_c;

	// Divider step.
	logic [DW:0]               trial_c;
	logic                      ge_c;

	// Shared multiplier.
	logic [MAW-1:0]            mul_a;
	logic [QW-1:0]             mul_b;
	logic [PW-1:0]             prod_c;

	// Rounding of the product for both the estimate step and the new covariance.
	logic [PW:0]               rsum_c;
	logic [RW-1:0]             rnd_c;
	logic signed [SW-1:0]      est_sum;
	logic signed [EST_W-1:0]   est_c;
	logic [COV_W-1:0]          pnew_c;

	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-EST_W-GAIN_OUT_W){1'b0}}, out_gain_q, out_est_q};

	assign pmid_sum = {1'b0, cov_q} + (COV_W+1)'(q_noise_q);
	assign pmid_c   = pmid_sum[COV_W] ? COV_MAX : pmid_sum[COV_W-1:0];

	assign den_c = DW'(pmid_q) + DW'(r_noise_q);
	assign num_c = NW'({pmid_q, {FRAC_BITS{1'b0}}}) + NW'(den_c >> 1);

	assign tgt_ext = TW'(sample_q) <<< FRAC_BITS;
	always_comb begin
		if (tgt_ext > TGT_HI) begin
			tgt_c = TGT_HI[EST_W-1:0];
		end else if (tgt_ext < TGT_LO) begin
			tgt_c = TGT_LO[EST_W-1:0];
		end else begin
			tgt_c = tgt_ext[EST_W-1:0];
		end
	end
	assign diff_c = (EST_W+1)'(tgt_c) - (EST_W+1)'(prior_q);

	assign trial_c = {rem_q, num_q[QW-1]};
	assign ge_c    = (trial_c >= {1'b0, den_q});

	// The multiplier forms gain * |difference| first, then (1 - gain) * predicted covariance.
	assign mul_a  = (state_q == ST_MUL1) ? mag_q : MAW'(pmid_q);
	assign mul_b  = (state_q == ST_MUL1) ? gain_q : ONE - gain_q;
	assign prod_c = PW'(mul_a) * PW'(mul_b);

	assign rsum_c = {1'b0, prod_q} + HALF;
	assign rnd_c  = rsum_c[PW:FRAC_BITS];

	always_comb begin
		if (neg_q) begin
			est_sum = SW'(prior_q) - $signed({{(SW-RW){1'b0}}, rnd_c});
		end else begin
			est_sum = SW'(prior_q) + $signed({{(SW-RW){1'b0}}, rnd_c});
		end
		if (est_sum > EST_HI) begin
			est_c = EST_HI[EST_W-1:0];
		end else if (est_sum < EST_LO) begin
			est_c = EST_LO[EST_W-1:0];
		end else begin
			est_c = est_sum[EST_W-1:0];
		end
	end

	assign pnew_c = (|rnd_c[RW-1:COV_W]) ? COV_MAX : rnd_c[COV_W-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= PROCESS_NOISE_RST;
			r_noise_q <= MEASUREMENT_NOISE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PROCESS_NOISE:     q_noise_q <= cfg_data;
				REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, filter state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prior_q     <= '0;
			cov_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A beat taken in the final state is replaced there by the new result.
			if (out_valid_q && m_axis_tready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == CW'(QW - 1)) begin
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN: begin
					// Hold here until the output register can take the result.
					if (out_free) begin
						prior_q     <= est_q;
						cov_q       <= pnew_c;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					sample_q <= s_axis_tdata[SAMPLE_WIDTH-1:0];
					pmid_q   <= pmid_c;
				end
			end
			ST_PREP: begin
				den_q      <= den_c;
				den_zero_q <= (den_c == '0);
				rem_q      <= DW'(num_c[NW-1:QW]);
				num_q      <= num_c[QW-1:0];
				quo_q      <= '0;
				cnt_q      <= '0;
				neg_q      <= diff_c[EST_W];
				mag_q      <= diff_c[EST_W] ? MAW'(-diff_c) : diff_c[EST_W-1:0];
			end
			ST_DIV: begin
				// Restoring division, one quotient bit per cycle, MSB first.
				rem_q <= ge_c ? DW'(trial_c - {1'b0, den_q}) : DW'(trial_c);
				num_q <= num_q << 1;
				quo_q <= {quo_q[QW-2:0], ge_c};
				cnt_q <= cnt_q + CW'(1);
			end
			ST_GAIN: begin
				if (den_zero_q) begin
					gain_q <= '0;
				end else if (quo_q > ONE) begin
					gain_q <= ONE;
				end else begin
					gain_q <= quo_q;
				end
			end
			ST_MUL1: prod_q <= prod_c;
			ST_MUL2: begin
				est_q  <= est_c;
				prod_q <= prod_c;
			end
			ST_FIN: begin
				if (out_free) begin
					out_est_q  <= est_q;
					out_gain_q <= GAIN_OUT_W'(gain_q);
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: design/skf_checker.sv
// Port-level checker for the scalar Kalman filter and its bind statement.
`default_nettype none
module skf_checker
	import skf_pkg::*;
#(
	parameter int FRAC_BITS    = 16
) (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_axis_tvalid,
	input wire                               s_axis_tready,
	input wire                               m_axis_tvalid,
	input wire                               m_axis_tready,
	input wire [OUT_TDATA_W-1:0]             m_axis_tdata
);

	logic in_beat;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	// A stalled result beat keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// The filter works on one sample at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_axis_tready)
		else $error("input ready right after an accepted beat");

	// A result never appears in the cycle right after a sample was taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(in_beat))
		else $error("result appeared one cycle after acceptance");

	// The gain never exceeds one.
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (FRAC_BITS > 16) ||
			(m_axis_tdata[EST_W+GAIN_OUT_W-1:EST_W] <= (17'd1 << FRAC_BITS)))
		else $error("gain above one");

endmodule

bind scalar_kalman_filter skf_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_skf_checker (.*);
`default_nettype wire
